// ----- sv/psc_pkg.sv -----
// Shared types, constants and saturation helpers for the soft clip waveshaper.
`timescale 1ns / 1ps

package psc_pkg;

	// Samples per transfer and foldback passes built into each lane.
	localparam int LANES      = 4;
	localparam int MAX_FOLDS  = 3;

	// Pipeline depth from the input register to the output register.
	localparam int NUM_STAGES = 13;

	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;

	typedef logic signed [23:0] sample_t;
	typedef logic signed [39:0] coef_t;

	// Register map, one 64-bit slot per register.
	typedef enum logic [2:0] {
		REG_SHAPING_ENABLE,
		REG_POLY_ORDER,
		REG_FOLD_COUNT,
		REG_COEF_A3,
		REG_COEF_A5,
		REG_COEF_A7,
		REG_CLIP_LIMIT,
		REG_OUT_GAIN
	} reg_idx_t;

	typedef struct packed {
		logic        shaping_enable;
		logic        poly_order;
		logic [1:0]  fold_count;
		coef_t       coef_a3;
		coef_t       coef_a5;
		coef_t       coef_a7;
		logic [22:0] clip_limit;
		logic [23:0] out_gain;
	} psc_cfg_t;

	localparam coef_t       RST_COEF_A3    = -40'sd155345;
	localparam logic [22:0] RST_CLIP_LIMIT = 23'd786432;
	localparam logic [23:0] RST_OUT_GAIN   = 24'd65536;

	// 1.0 in Q19.20, last Horner constant.
	localparam coef_t       ONE_Q20        = 40'sd1048576;

	localparam logic signed [63:0] MAX40 = 64'sd549755813887;
	localparam logic signed [63:0] MIN40 = -64'sd549755813888;
	localparam logic signed [63:0] MAX24 = 64'sd8388607;
	localparam logic signed [63:0] MIN24 = -64'sd8388608;

	function automatic coef_t sat40(input logic signed [63:0] v);
		coef_t r;
		if (v > MAX40) begin
			r = MAX40[39:0];
		end else if (v < MIN40) begin
			r = MIN40[39:0];
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

	function automatic sample_t sat24(input logic signed [63:0] v);
		sample_t r;
		if (v > MAX24) begin
			r = MAX24[23:0];
		end else if (v < MIN24) begin
			r = MIN24[23:0];
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/psc_regs.sv -----
// APB register file holding the shaper configuration.
`timescale 1ns / 1ps

module psc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [psc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [psc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [psc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output psc_pkg::psc_cfg_t              cfg
);
	import psc_pkg::*;

	psc_cfg_t cfg_q;
	reg_idx_t idx;

	// Slots are 8 bytes apart; the byte offset inside a slot is ignored.
	assign idx    = reg_idx_t'(paddr[5:3]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shaping_enable <= 1'b1;
			cfg_q.poly_order     <= 1'b0;
			cfg_q.fold_count     <= 2'd0;
			cfg_q.coef_a3        <= RST_COEF_A3;
			cfg_q.coef_a5        <= '0;
			cfg_q.coef_a7        <= '0;
			cfg_q.clip_limit     <= RST_CLIP_LIMIT;
			cfg_q.out_gain       <= RST_OUT_GAIN;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_SHAPING_ENABLE: cfg_q.shaping_enable <= pwdata[0];
				REG_POLY_ORDER:     cfg_q.poly_order     <= pwdata[0];
				REG_FOLD_COUNT:     cfg_q.fold_count     <= pwdata[1:0];
				REG_COEF_A3:        cfg_q.coef_a3        <= pwdata[39:0];
				REG_COEF_A5:        cfg_q.coef_a5        <= pwdata[39:0];
				REG_COEF_A7:        cfg_q.coef_a7        <= pwdata[39:0];
				REG_CLIP_LIMIT:     cfg_q.clip_limit     <= pwdata[22:0];
				REG_OUT_GAIN:       cfg_q.out_gain       <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SHAPING_ENABLE: prdata = {63'd0, cfg_q.shaping_enable};
			REG_POLY_ORDER:     prdata = {63'd0, cfg_q.poly_order};
			REG_FOLD_COUNT:     prdata = {62'd0, cfg_q.fold_count};
			REG_COEF_A3:        prdata = {{24{cfg_q.coef_a3[39]}}, cfg_q.coef_a3};
			REG_COEF_A5:        prdata = {{24{cfg_q.coef_a5[39]}}, cfg_q.coef_a5};
			REG_COEF_A7:        prdata = {{24{cfg_q.coef_a7[39]}}, cfg_q.coef_a7};
			REG_CLIP_LIMIT:     prdata = {41'd0, cfg_q.clip_limit};
			REG_OUT_GAIN:       prdata = {40'd0, cfg_q.out_gain};
			default:            prdata = '0;
		endcase
	end

endmodule

// ----- sv/psc_horner.sv -----
// One Horner step: p*x2 rounded to Q.20, plus constant, saturated to 40 bits.
`timescale 1ns / 1ps

module psc_horner (
	input  logic          clk,
	input  logic          en_mul,
	input  logic          en_add,
	input  psc_pkg::coef_t p,
	input  logic [28:0]   x2,
	input  psc_pkg::coef_t c,
	output psc_pkg::coef_t result
);
	import psc_pkg::*;

	logic signed [19:0] a_hi;
	logic        [19:0] a_lo;
	logic signed [49:0] pp_hi_s1;
	logic        [48:0] pp_lo_s1;
	logic        [49:0] lo_rnd;
	logic signed [51:0] acc;
	coef_t              result_s2;

	// p split at bit 20 keeps each partial product within 50 bits.
	assign a_hi = $signed(p[39:20]);
	assign a_lo = p[19:0];

	// hi part is already aligned to 2^20, so only the low product is rounded
	assign lo_rnd = {1'b0, pp_lo_s1} + 50'd524288;
	assign acc    = $signed({{2{pp_hi_s1[49]}}, pp_hi_s1})
	              + $signed({22'd0, lo_rnd[49:20]})
	              + $signed({{12{c[39]}}, c});

	always_ff @(posedge clk) begin
		if (en_mul) begin
			pp_hi_s1 <= a_hi * $signed({1'b0, x2});
			pp_lo_s1 <= a_lo * x2;
		end
		if (en_add) begin
			result_s2 <= sat40({{12{acc[51]}}, acc});
		end
	end

	assign result = result_s2;

endmodule

// ----- sv/psc_lane.sv -----
// One sample lane: foldback, clamp, odd polynomial, output gain, saturation; raw bypass when shaping is off.
`timescale 1ns / 1ps

module psc_lane (
	input  logic                             clk,
	input  logic [psc_pkg::NUM_STAGES-1:0]   stage_en,
	input  psc_pkg::psc_cfg_t                cfg,
	input  psc_pkg::sample_t                 sample,
	output psc_pkg::sample_t                 result
);
	import psc_pkg::*;

	// Fold / clamp (feeds s1)
	logic signed [25:0] lim;
	logic signed [25:0] v;
	sample_t            x_fold;

	// Carried operands, indexed by stage
	sample_t raw_s [1:12];
	sample_t x_s   [1:9];
	logic [28:0] x2_s [3:7];

	logic signed [47:0] sq_full;
	logic        [46:0] sq_s2;
	logic        [47:0] x2_sum;

	coef_t p1_s5;
	coef_t p2_s7;
	coef_t p3_s9;
	coef_t p3_in;

	logic signed [19:0] p_hi;
	logic signed [20:0] p_lo;
	logic signed [43:0] pa_s10;
	logic signed [44:0] pb_s10;
	logic signed [44:0] t_sum;
	logic signed [45:0] y1_sum;
	coef_t              y1_s11;

	logic signed [19:0] y_hi;
	logic        [19:0] y_lo;
	logic signed [44:0] ga_s12;
	logic        [43:0] gb_s12;
	logic        [44:0] gb_rnd;
	logic signed [49:0] y_sum;
	sample_t            y_s13;

	// Each pass mirrors about the nearer limit; magnitude stays within 2^23.
	always_comb begin
		lim = $signed({3'b000, cfg.clip_limit});
		v   = {{2{sample[23]}}, sample};
		for (int k = 0; k < MAX_FOLDS; k++) begin
			if (k < int'(cfg.fold_count)) begin
				if (v < -lim) begin
					v = -(lim <<< 1) - v;
				end else if (v > lim) begin
					v = (lim <<< 1) - v;
				end
			end
		end
		if (v < -lim) begin
			v = -lim;
		end else if (v > lim) begin
			v = lim;
		end
		x_fold = v[23:0];
	end

	assign sq_full = x_s[1] * x_s[1];
	assign x2_sum  = {1'b0, sq_s2} + 48'd131072;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			raw_s[1] <= sample;
			x_s[1]   <= x_fold;
		end
		for (int k = 2; k <= 12; k++) begin
			if (stage_en[k-1]) begin
				raw_s[k] <= raw_s[k-1];
			end
		end
		for (int k = 2; k <= 9; k++) begin
			if (stage_en[k-1]) begin
				x_s[k] <= x_s[k-1];
			end
		end
		if (stage_en[1]) begin
			sq_s2 <= sq_full[46:0];
		end
		if (stage_en[2]) begin
			x2_s[3] <= x2_sum[46:18];
		end
		for (int k = 4; k <= 7; k++) begin
			if (stage_en[k-1]) begin
				x2_s[k] <= x2_s[k-1];
			end
		end
	end

	// Horner chain: a7 -> +a5 -> +a3 -> +1. Third order enters at the last step.
	psc_horner u_h1 (
		.clk    (clk),
		.en_mul (stage_en[3]),
		.en_add (stage_en[4]),
		.p      (cfg.coef_a7),
		.x2     (x2_s[3]),
		.c      (cfg.coef_a5),
		.result (p1_s5)
	);

	psc_horner u_h2 (
		.clk    (clk),
		.en_mul (stage_en[5]),
		.en_add (stage_en[6]),
		.p      (p1_s5),
		.x2     (x2_s[5]),
		.c      (cfg.coef_a3),
		.result (p2_s7)
	);

	assign p3_in = cfg.poly_order ? p2_s7 : cfg.coef_a3;

	psc_horner u_h3 (
		.clk    (clk),
		.en_mul (stage_en[7]),
		.en_add (stage_en[8]),
		.p      (p3_in),
		.x2     (x2_s[7]),
		.c      (ONE_Q20),
		.result (p3_s9)
	);

	// y1 = round(p*x / 2^20)
	assign p_hi   = $signed(p3_s9[39:20]);
	assign p_lo   = $signed({1'b0, p3_s9[19:0]});
	assign t_sum  = pb_s10 + 45'sd524288;
	assign y1_sum = $signed({{2{pa_s10[43]}}, pa_s10}) + $signed({{21{t_sum[44]}}, t_sum[44:20]});

	// y = round(y1*gain / 2^16)
	assign y_hi   = $signed(y1_s11[39:20]);
	assign y_lo   = y1_s11[19:0];
	assign gb_rnd = {1'b0, gb_s12} + 45'd32768;
	assign y_sum  = $signed({ga_s12[44], ga_s12, 4'b0000}) + $signed({21'd0, gb_rnd[44:16]});

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			pa_s10 <= p_hi * x_s[9];
			pb_s10 <= p_lo * x_s[9];
		end
		if (stage_en[10]) begin
			y1_s11 <= sat40({{18{y1_sum[45]}}, y1_sum});
		end
		if (stage_en[11]) begin
			ga_s12 <= y_hi * $signed({1'b0, cfg.out_gain});
			gb_s12 <= y_lo * cfg.out_gain;
		end
		if (stage_en[12]) begin
			y_s13 <= cfg.shaping_enable ? sat24({{14{y_sum[49]}}, y_sum}) : raw_s[12];
		end
	end

	assign result = y_s13;

endmodule

// ----- sv/polynomial_soft_clip_waveshaper_core.sv -----
// Top level of the soft clip waveshaper: APB registers, four lanes, handshake.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  src      | src_valid/src_stall | sample_in_0..3 (Q4.19), block_end_in
//  dst      | dst_valid/dst_stall | sample_out_0..3 (Q4.19), block_end_out
//  apb      | psel/penable/pready | paddr, pwdata, prdata (64-bit slots)
//
// One transfer per clock sustained while dst does not stall; the stages form the multiplier
// chain (square, three Horner steps, p*x, output gain, each multiply then add).
// Each stage advances whenever any stage at or after it is empty, so bubbles
// collapse and src is held off only when every stage is full and dst stalls.
// Reset clears the stage valid bits and loads register defaults; no clearing
// pass is needed.
`timescale 1ns / 1ps

module polynomial_soft_clip_waveshaper_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [psc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [psc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [psc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	// input channel
	input  logic                           src_valid,
	output logic                           src_stall,
	input  psc_pkg::sample_t               sample_in_0,
	input  psc_pkg::sample_t               sample_in_1,
	input  psc_pkg::sample_t               sample_in_2,
	input  psc_pkg::sample_t               sample_in_3,
	input  logic                           block_end_in,
	// output channel
	output logic                           dst_valid,
	input  logic                           dst_stall,
	output psc_pkg::sample_t               sample_out_0,
	output psc_pkg::sample_t               sample_out_1,
	output psc_pkg::sample_t               sample_out_2,
	output psc_pkg::sample_t               sample_out_3,
	output logic                           block_end_out
);
	import psc_pkg::*;

	psc_cfg_t              cfg;
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] stage_en;
	logic                  end_s [NUM_STAGES];
	sample_t               lane_in  [LANES];
	sample_t               lane_out [LANES];

	psc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage k may load unless it and everything downstream is full and stalled.
	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
		assign stage_en[k] = ~(dst_stall & (&vld_q[NUM_STAGES-1:k]));
	end

	assign src_stall = ~stage_en[0];
	assign dst_valid = vld_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_q[0] <= src_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// block end mark rides alongside the lanes
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			end_s[0] <= block_end_in;
		end
		for (int k = 1; k < NUM_STAGES; k++) begin
			if (stage_en[k]) begin
				end_s[k] <= end_s[k-1];
			end
		end
	end

	assign lane_in[0] = sample_in_0;
	assign lane_in[1] = sample_in_1;
	assign lane_in[2] = sample_in_2;
	assign lane_in[3] = sample_in_3;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		psc_lane u_lane (
			.clk      (clk),
			.stage_en (stage_en),
			.cfg      (cfg),
			.sample   (lane_in[i]),
			.result   (lane_out[i])
		);
	end

	// Output register is the last lane stage; lanes and mark merge here.
	assign sample_out_0  = lane_out[0];
	assign sample_out_1  = lane_out[1];
	assign sample_out_2  = lane_out[2];
	assign sample_out_3  = lane_out[3];
	assign block_end_out = end_s[NUM_STAGES-1];

endmodule

// ----- sv/psc_checker.sv -----
// Port-level checks for the soft clip waveshaper, bound to the top level.
`timescale 1ns / 1ps

module psc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [psc_pkg::APB_ADDR_W-1:0] paddr,
	input logic [psc_pkg::APB_DATA_W-1:0] pwdata,
	input logic [psc_pkg::APB_DATA_W-1:0] prdata,
	input logic                           pready,
	input logic                           src_stall,
	input logic                           dst_valid,
	input logic                           dst_stall,
	input psc_pkg::sample_t               sample_out_0,
	input logic                           block_end_out
);
	import psc_pkg::*;

	// Input is only held off when the output is full and stalled.
	a_src_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (dst_valid && dst_stall))
		else $error("src stalled without a stalled output");

	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_stall) |=>
			(dst_valid && $stable(sample_out_0) && $stable(block_end_out)))
		else $error("stalled output transfer changed");

	a_gain_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[5:3] == REG_OUT_GAIN) |=>
			((paddr[5:3] != REG_OUT_GAIN) ||
			 (prdata[23:0] == $past(pwdata[23:0]) && prdata[63:24] == '0)))
		else $error("out_gain readback mismatch");

	a_limit_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[5:3] == REG_CLIP_LIMIT) |=>
			((paddr[5:3] != REG_CLIP_LIMIT) ||
			 (prdata[22:0] == $past(pwdata[22:0]) && prdata[63:23] == '0)))
		else $error("clip_limit readback mismatch");

endmodule

bind polynomial_soft_clip_waveshaper_core psc_checker u_psc_checker (.*);
